### rtl/rrts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rrts_pkg;
   localparam int NumProcs  = 16;
   localparam int PidBits   = 4;
   localparam int TickBits  = 32;

   typedef enum logic [2:0] {
      KIND_TICK    = 3'd0,
      KIND_ENQUEUE = 3'd1,
      KIND_REMOVE  = 3'd2,
      KIND_YIELD   = 3'd3,
      KIND_SLEEP   = 3'd4,
      KIND_EXIT    = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ST_UNUSED  = 2'd0,
      ST_READY   = 2'd1,
      ST_RUNNING = 2'd2,
      ST_BLOCKED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WAKE,
      PH_ROTATE,
      PH_DROP,
      PH_PICK,
      PH_DONE
   } phase_type;

   // broadcast from the sequencer to every cell at once
   typedef struct packed {
      logic                  set_status;
      logic [PidBits-1:0]    status_pid;
      status_type            status_val;
      logic                  set_deadline;
      logic [TickBits-1:0]   deadline_val;
      logic                  wake_scan;
      logic [PidBits-1:0]    wake_pid;
      logic [TickBits-1:0]   tick_val;
   } cell_cmd_type;

   // a cell's report: its status and whether it is due to wake
   typedef struct packed {
      status_type            status;
      logic                  due;
   } cell_rpt_type;
endpackage
`default_nettype wire

### rtl/rrts_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One process table entry. The wake scan token passes along the row, one cell
// per cycle, so each cell compares its own deadline only when it holds it.
module rrts_cell (
   input  wire                       clock,
   input  wire                       reset,
   input  wire  [rrts_pkg::PidBits-1:0] my_pid,
   input  rrts_pkg::cell_cmd_type    cmd,
   output rrts_pkg::cell_rpt_type    rpt
);
   import rrts_pkg::*;

   status_type          status_ff, status_in;
   logic [TickBits-1:0] deadline_ff, deadline_in;

   always_comb begin
      status_in   = status_ff;
      deadline_in = deadline_ff;
      if (cmd.set_status && cmd.status_pid == my_pid) begin
         status_in = cmd.status_val;
      end
      if (cmd.set_deadline && cmd.status_pid == my_pid) begin
         deadline_in = cmd.deadline_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff   <= ST_UNUSED;
         deadline_ff <= '0;
      end else begin
         status_ff   <= status_in;
         deadline_ff <= deadline_in;
      end
   end

   assign rpt.status = status_ff;
   assign rpt.due = cmd.wake_scan && cmd.wake_pid == my_pid && status_ff == ST_BLOCKED
                    && deadline_ff != '0 && deadline_ff <= cmd.tick_val;
endmodule
`default_nettype wire

### rtl/rrts_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Doubly linked ready queue: link arrays, membership bits, head and tail.
// One operation a cycle: append (moves an entry already queued) or remove.
module rrts_queue (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          op_add,
   input  wire                          op_remove,
   input  wire  [rrts_pkg::PidBits-1:0] op_pid,
   output logic [rrts_pkg::PidBits-1:0] head,
   output logic                         nonempty
);
   import rrts_pkg::*;

   logic [PidBits-1:0]  fwd_ff [NumProcs];
   logic [PidBits-1:0]  bwd_ff [NumProcs];
   logic [NumProcs-1:0] inq_ff, inq_in;
   logic [PidBits-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic                ne_ff, ne_in;
   logic [PidBits-1:0]  f, b;
   logic                rm, single;

   always_comb begin
      f      = fwd_ff[op_pid];
      b      = bwd_ff[op_pid];
      rm     = (op_add || op_remove) && inq_ff[op_pid] && ne_ff;
      single = head_ff == op_pid && tail_ff == op_pid;
      inq_in  = inq_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      ne_in   = ne_ff;
      if (rm) begin
         inq_in[op_pid] = 1'b0;
         if (single) begin
            ne_in   = 1'b0;
            head_in = '0;
            tail_in = '0;
         end else begin
            if (head_ff == op_pid) head_in = f;
            if (tail_ff == op_pid) tail_in = b;
         end
      end
      if (op_add) begin
         inq_in[op_pid] = 1'b1;
         if (!ne_in) head_in = op_pid;
         tail_in = op_pid;
         ne_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inq_ff  <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         ne_ff   <= 1'b0;
      end else begin
         inq_ff  <= inq_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         ne_ff   <= ne_in;
      end
   end

   // links need no reset: only queued entries are ever read
   always_ff @(posedge clock) begin
      if (rm && !single) begin
         // a re-appended tail rewrites its predecessor link below
         if (head_ff != op_pid && !(op_add && tail_ff == op_pid)) fwd_ff[b] <= f;
         if (tail_ff != op_pid) bwd_ff[f] <= b;
      end
      if (op_add) begin
         fwd_ff[op_pid] <= op_pid;
         if (rm && single || !ne_ff) begin
            bwd_ff[op_pid] <= op_pid;
         end else begin
            // tail after removal; a moved tail writes its successor link here
            bwd_ff[op_pid] <= (rm && tail_ff == op_pid) ? b : tail_ff;
            if (rm && tail_ff == op_pid) fwd_ff[b] <= op_pid;
            else                         fwd_ff[tail_ff] <= op_pid;
         end
      end
   end

   assign head     = head_ff;
   assign nonempty = ne_ff;
endmodule
`default_nettype wire

### rtl/round_robin_task_scheduler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Round-robin task scheduler over a table of 16 processes.
// req_ carries one request per transfer: kind, pid and wake_tick.
// rsp_ returns one result per request: the running process, switch flag,
// saved process, save flag, queue-empty flag and the tick count.
// Requests are handled one at a time by a sequencer next to a row of process
// cells. An enqueue, a remove, an empty-queue yield, an unknown kind, or a
// sleep or exit of a process that is not running is done in the wake phase
// alone. A tick walks a scan pointer along the row, one cell a cycle, and goes
// on to rotate and pick when the running process is not idle process 0 and
// the queue is not empty. A yield rotates, drops stale queue heads and picks;
// a sleep or exit of the running process drops stale queue heads and picks.
// The result becomes valid in the same cycle as the next request can be taken.
// The result sits in an output register; while the receiver stalls the next
// request is still taken and processed, and its result is held until the
// register frees.
// Reset (synchronous, active high) marks all processes unused, empties the
// queue, makes idle process 0 run and clears the tick count.
module round_robin_task_scheduler_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,   // kind[2:0], pid[6:3], wake_tick[38:7], zero
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata    // running_pid[3:0], switched[4], saved_pid[8:5],
                                    // save_previous[9], queue_empty[10],
                                    // tick_now[42:11], zero
);
   import rrts_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [2:0]         kind_ff, kind_in;
   logic [PidBits-1:0] pid_ff, pid_in, scan_ff, scan_in, cur_ff, cur_in;
   logic [PidBits-1:0] sav_ff, sav_in, start_ff, start_in;
   logic [TickBits-1:0] tick_ff, tick_in, wt_ff, wt_in;
   logic               sw_ff, sw_in, svp_ff, svp_in;
   logic               ov_ff, ov_in;
   logic [47:0]        od_ff, od_in;
   logic               cnt_ok;

   cell_cmd_type       cmd;
   cell_rpt_type       rpt [NumProcs];
   status_type         st [NumProcs];
   logic               due_any;
   logic               q_add, q_rm, q_ne;
   logic [PidBits-1:0] q_pid, q_head;

   for (genvar g = 0; g < NumProcs; g++) begin : g_cell
      rrts_cell u_cell (
         .clock(clock), .reset(reset), .my_pid(PidBits'(g)), .cmd(cmd), .rpt(rpt[g])
      );
      assign st[g] = rpt[g].status;
   end

   rrts_queue u_queue (
      .clock(clock), .reset(reset), .op_add(q_add), .op_remove(q_rm),
      .op_pid(q_pid), .head(q_head), .nonempty(q_ne)
   );

   always_comb begin
      due_any = 1'b0;
      for (int i = 0; i < NumProcs; i++) due_any = due_any | rpt[i].due;
   end

   assign req_tready = phase_ff == PH_IDLE;
   assign cnt_ok = 1'b1;

   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      pid_in   = pid_ff;
      wt_in    = wt_ff;
      scan_in  = scan_ff;
      cur_in   = cur_ff;
      sav_in   = sav_ff;
      start_in = start_ff;
      tick_in  = tick_ff;
      sw_in    = sw_ff;
      svp_in   = svp_ff;
      ov_in    = ov_ff && !rsp_tready;
      od_in    = od_ff;
      cmd      = '0;
      cmd.tick_val = tick_ff;
      cmd.wake_pid = scan_ff;
      q_add = 1'b0;
      q_rm  = 1'b0;
      q_pid = pid_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (req_tvalid && req_tready) begin
               kind_in = req_tdata[2:0];
               pid_in  = req_tdata[6:3];
               wt_in   = req_tdata[38:7];
               sw_in   = 1'b0;
               svp_in  = 1'b0;
               sav_in  = '0;
               phase_in = PH_WAKE;
               scan_in  = PidBits'(1);
            end
         end
         PH_WAKE: begin
            unique case (kind_ff)
               KIND_TICK: begin
                  if (scan_ff == PidBits'(1) && !cnt_ok) phase_in = PH_WAKE;
                  cmd.wake_scan = 1'b1;
                  if (due_any) begin
                     cmd.set_status   = 1'b1;
                     cmd.status_pid   = scan_ff;
                     cmd.status_val   = ST_READY;
                     cmd.set_deadline = 1'b1;
                     cmd.deadline_val = '0;
                     q_add = 1'b1;
                     q_pid = scan_ff;
                  end
                  scan_in = scan_ff + 1'b1;
                  if (scan_ff == PidBits'(NumProcs - 1)) begin
                     phase_in = (q_ne || due_any) && cur_ff != '0 ? PH_ROTATE : PH_DONE;
                  end
               end
               KIND_ENQUEUE: begin
                  if (pid_ff != '0 && !(pid_ff == cur_ff && st[pid_ff] == ST_RUNNING)) begin
                     cmd.set_status = 1'b1;
                     cmd.status_pid = pid_ff;
                     cmd.status_val = ST_READY;
                     q_add = 1'b1;
                  end
                  phase_in = PH_DONE;
               end
               KIND_REMOVE: begin
                  q_rm = 1'b1;
                  phase_in = PH_DONE;
               end
               KIND_YIELD: begin
                  phase_in = q_ne ? PH_ROTATE : PH_DONE;
               end
               KIND_SLEEP, KIND_EXIT: begin
                  if (pid_ff != '0) begin
                     cmd.set_status   = 1'b1;
                     cmd.status_pid   = pid_ff;
                     cmd.status_val   = kind_ff == KIND_SLEEP ? ST_BLOCKED : ST_UNUSED;
                     cmd.set_deadline = 1'b1;
                     cmd.deadline_val = kind_ff == KIND_SLEEP ? wt_ff : '0;
                     q_rm = 1'b1;
                     phase_in = pid_ff == cur_ff ? PH_DROP : PH_DONE;
                     start_in = cur_ff;
                     scan_in  = '0;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               default: phase_in = PH_DONE;
            endcase
            if (kind_ff == KIND_TICK && scan_ff == '0) begin
               // never reached: the scan starts at one
               phase_in = PH_DONE;
            end
            if (kind_ff == KIND_TICK && scan_ff == PidBits'(1)) tick_in = tick_ff + 1'b1;
            if (kind_ff == KIND_TICK && scan_ff == PidBits'(1)) cmd.tick_val = tick_ff + 1'b1;
         end
         PH_ROTATE: begin
            start_in = cur_ff;
            scan_in  = '0;
            if (st[cur_ff] == ST_RUNNING && cur_ff != '0) begin
               cmd.set_status = 1'b1;
               cmd.status_pid = cur_ff;
               cmd.status_val = ST_READY;
               q_add = 1'b1;
               q_pid = cur_ff;
            end
            phase_in = PH_DROP;
         end
         PH_DROP: begin
            // drop one stale head a cycle, bounded by the table size
            if (q_ne && st[q_head] != ST_READY && scan_ff != PidBits'(NumProcs - 1)) begin
               q_rm    = 1'b1;
               q_pid   = q_head;
               scan_in = scan_ff + 1'b1;
            end else begin
               phase_in = PH_PICK;
            end
         end
         PH_PICK: begin
            if (q_ne && st[q_head] != ST_READY) begin
               q_rm  = 1'b1;
               q_pid = q_head;
               phase_in = PH_PICK;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status_pid = (q_ne) ? q_head : '0;
               cmd.status_val = ST_RUNNING;
               if (cmd.status_pid != start_ff) begin
                  sw_in  = 1'b1;
                  sav_in = start_ff;
                  svp_in = cmd.status_pid == start_ff ? 1'b1 : st[start_ff] != ST_UNUSED;
                  cur_in = cmd.status_pid;
               end
               phase_in = PH_DONE;
            end
         end
         PH_DONE: begin
            if (!ov_ff || rsp_tready) begin
               ov_in = 1'b1;
               od_in = {5'd0, tick_ff, !q_ne, svp_ff, sav_ff, sw_ff, cur_ff};
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cur_ff   <= '0;
         tick_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cur_ff   <= cur_in;
         tick_ff  <= tick_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      pid_ff   <= pid_in;
      wt_ff    <= wt_in;
      scan_ff  <= scan_in;
      sav_ff   <= sav_in;
      start_ff <= start_in;
      sw_ff    <= sw_in;
      svp_ff   <= svp_in;
      od_ff    <= od_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_idle_only_accept: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> phase_ff == PH_IDLE)
      else $error("request accepted while busy");
   a_switch_saved: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> rsp_tdata[8:5] != rsp_tdata[3:0])
      else $error("switch reported to the same process");
endmodule
`default_nettype wire
